@@ src/dfa_layered_domain_filter_defines.svh @@
// Assertion macros for the layered DFA domain filter
`ifndef DFA_LAYERED_DOMAIN_FILTER_DEFINES_SVH
`define DFA_LAYERED_DOMAIN_FILTER_DEFINES_SVH
// assert an implication on every clock edge outside reset
`define DLDF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// assert an implication whose consequent is checked in the next cycle
`define DLDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ src/dldf_pkg.sv @@
// Package: types and constants for the layered DFA domain filter
package dldf_pkg;
  localparam int MaxVarsDef     = 16;
  localparam int NumStatesDef   = 16;
  localparam int NumSymbolsDef  = 16;
  localparam int DomBits        = 16;
  localparam int ResultLimit    = 16;
  localparam int CmdW           = 2;
  localparam int FieldW         = 4;
  localparam int LenW           = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_WR_TRANS = 2'd0,
    CMD_WR_DOM   = 2'd1,
    CMD_PROP     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_FINAL_MASK = 1'b0,
    CFG_SEQ_LEN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_BWD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [FieldW-1:0] from_state;
    logic [FieldW-1:0] symbol;
    logic [FieldW-1:0] to_state;
    logic              edge_defined;
    logic [FieldW-1:0] var_index;
    logic [DomBits-1:0] domain_mask;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0]  out_var;
    logic [DomBits-1:0] pruned_mask;
    logic               wiped_out;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [0:0]         index;
    logic [DomBits-1:0] data;
  } cfg_item_t;
endpackage

@@ src/dldf_if.sv @@
// Interfaces: valid/ready channels for items, results and configuration
interface dldf_in_if;
  import dldf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dldf_out_if;
  import dldf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dldf_cfg_if;
  import dldf_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/dldf_edge_unit.sv @@
// Shared edge unit: evaluates all symbols of one state against one layer
module dldf_edge_unit #(
  parameter int NumStates  = dldf_pkg::NumStatesDef,
  parameter int NumSymbols = dldf_pkg::NumSymbolsDef
) (
  input  logic [NumSymbols-1:0]                      sym_en_i,
  input  logic [NumSymbols-1:0]                      edge_ok_i,
  input  logic [NumSymbols-1:0][$clog2(NumStates)-1:0] edge_to_i,
  input  logic [NumStates-1:0]                       support_i,
  output logic [NumStates-1:0]                       targets_o,
  output logic [NumSymbols-1:0]                      vals_o
);
  import dldf_pkg::*;
  always_comb begin
    targets_o = '0;
    vals_o    = '0;
    for (int v = 0; v < NumSymbols; v++) begin
      if (sym_en_i[v] && edge_ok_i[v]) begin
        targets_o[edge_to_i[v]] = 1'b1;
        vals_o[v] = support_i[edge_to_i[v]];
      end
    end
  end
endmodule

@@ src/dfa_layered_domain_filter.sv @@
// Top level: layered DFA domain filter with a per-state sequencer
// Writes are registered; propagate runs a forward and then a backward sweep,
// using one shared edge unit that visits one state of one layer per cycle.
// Results stream out one per cycle after the backward sweep, held under back-pressure.
// Reset clears control, configuration and layer reach sets; the transition table
// sits in a memory with one valid bit per state row, cleared by reset.
module dfa_layered_domain_filter
  import dldf_pkg::*;
#(
  parameter int MAX_VARS       = dldf_pkg::MaxVarsDef,
  parameter int NUM_DFA_STATES = dldf_pkg::NumStatesDef,
  parameter int NUM_SYMBOLS    = dldf_pkg::NumSymbolsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  dldf_in_if.sink    in_if,
  dldf_out_if.source out_if,
  dldf_cfg_if.sink   cfg_if
);
  import dldf_pkg::*;
`include "dfa_layered_domain_filter_defines.svh"

  localparam int SW    = $clog2(NUM_DFA_STATES);
  localparam int VW    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int LimI  = (MAX_VARS < ResultLimit) ? MAX_VARS : ResultLimit;
  localparam int LayW  = $clog2(LimI + 1);
  localparam int KW    = (LimI > 1) ? $clog2(LimI) : 1;
  localparam int NSym  = (NUM_SYMBOLS < DomBits) ? NUM_SYMBOLS : DomBits;

  typedef logic [NUM_SYMBOLS-1:0][SW:0] row_t;

  row_t                       ttab_q [NUM_DFA_STATES];
  logic [NUM_DFA_STATES-1:0]  row_valid_q;
  logic [DomBits-1:0]         dom_q  [MAX_VARS];
  logic [NUM_DFA_STATES-1:0]  fwd_q  [LimI+1];
  logic [NUM_DFA_STATES-1:0]  bwd_q;
  logic [NUM_DFA_STATES-1:0]  acc_q, acc_d;
  logic [DomBits-1:0]         keep_q [LimI];
  logic [DomBits-1:0]         vals_q, vals_d;
  logic [DomBits-1:0]         fmask_q;
  logic [LenW-1:0]            slen_q;
  state_e                     state_q, state_d;
  logic [LayW-1:0]            lay_q, lay_d, n_q;
  logic [SW-1:0]              st_q, st_d;
  out_item_t                  out_q;
  logic                       ovld_q;

  logic [LayW-1:0] n_c;
  always_comb begin
    if (slen_q == '0) n_c = LayW'(1);
    else if (32'(slen_q) > LimI) n_c = LayW'(LimI);
    else n_c = LayW'(slen_q);
  end

  in_item_t it;
  assign it = in_if.data;
  assign in_if.ready = (state_q == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  wire in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmask_q <= '0;
      slen_q  <= LenW'(1);
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_e'(cfg_if.data.index))
        CFG_FINAL_MASK: fmask_q <= cfg_if.data.data;
        CFG_SEQ_LEN:    slen_q  <= cfg_if.data.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // edge unit operands for current layer/state
  logic [VW-1:0]   layv;
  logic [KW-1:0]   layk;
  logic [DomBits-1:0] dom_c;
  row_t            row_c;
  row_t            row_wr;
  logic [NUM_SYMBOLS-1:0] sym_en, edge_ok;
  logic [NUM_SYMBOLS-1:0][SW-1:0] edge_to;
  logic [NUM_DFA_STATES-1:0] sup_c, tgt_c;
  logic [NUM_SYMBOLS-1:0] vals_c;
  logic                 st_live;

  assign layv  = VW'(lay_q);
  assign layk  = KW'(lay_q);
  assign dom_c = dom_q[layv];
  assign row_c = ttab_q[st_q];
  assign st_live = fwd_q[lay_q][st_q] && row_valid_q[st_q];
  always_comb begin
    for (int v = 0; v < NUM_SYMBOLS; v++) begin
      sym_en[v]  = (v < NSym) ? dom_c[v % DomBits] : 1'b0;
      edge_ok[v] = row_c[v][SW] && st_live;
      edge_to[v] = row_c[v][SW-1:0];
    end
  end
  assign sup_c = (state_q == ST_BWD) ? bwd_q : '0;

  always_comb begin
    row_wr = row_valid_q[SW'(it.from_state)] ? ttab_q[SW'(it.from_state)] : '0;
    row_wr[$clog2(NUM_SYMBOLS)'(it.symbol)] =
      (it.edge_defined && 32'(it.to_state) < NUM_DFA_STATES) ?
      {1'b1, SW'(it.to_state)} : '0;
  end

  dldf_edge_unit #(.NumStates(NUM_DFA_STATES), .NumSymbols(NUM_SYMBOLS)) u_edge (
    .sym_en_i(sym_en), .edge_ok_i(edge_ok), .edge_to_i(edge_to),
    .support_i(sup_c), .targets_o(tgt_c), .vals_o(vals_c)
  );

  logic last_st;
  assign last_st = (32'(st_q) == NUM_DFA_STATES - 1);

  always_comb begin
    state_d = state_q;
    lay_d   = lay_q;
    st_d    = st_q;
    acc_d   = acc_q;
    vals_d  = vals_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && cmd_e'(it.cmd) == CMD_PROP) begin
          state_d = ST_FWD; lay_d = '0; st_d = '0; acc_d = '0;
        end
      end
      ST_FWD: begin
        acc_d = acc_q | tgt_c;
        st_d  = st_q + SW'(1);
        if (last_st) begin
          acc_d = '0;
          st_d  = '0;
          if (lay_q + LayW'(1) == n_q) begin
            state_d = ST_BWD;
            lay_d   = n_q - LayW'(1);
            vals_d  = '0;
          end else lay_d = lay_q + LayW'(1);
        end
      end
      ST_BWD: begin
        if (|vals_c) acc_d[st_q] = 1'b1;
        vals_d = vals_q | DomBits'(vals_c);
        st_d   = st_q + SW'(1);
        if (last_st) begin
          acc_d = '0; st_d = '0; vals_d = '0;
          if (lay_q == '0) state_d = ST_EMIT;
          else lay_d = lay_q - LayW'(1);
        end
      end
      ST_EMIT: begin
        if (!ovld_q || out_if.ready) begin
          if (lay_q + LayW'(1) == n_q) state_d = ST_IDLE;
          else lay_d = lay_q + LayW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lay_q <= '0; st_q <= '0; acc_q <= '0; vals_q <= '0; n_q <= LayW'(1);
      row_valid_q <= '0;
      bwd_q <= '0;
      ovld_q <= 1'b0;
      for (int i = 0; i <= LimI; i++) fwd_q[i] <= '0;
    end else begin
      state_q <= state_d; lay_q <= lay_d; st_q <= st_d;
      acc_q <= acc_d; vals_q <= vals_d;
      if (state_q == ST_IDLE && in_fire && cmd_e'(it.cmd) == CMD_PROP) begin
        n_q <= n_c;
        fwd_q[0] <= NUM_DFA_STATES'(1);
      end
      if (in_fire && cmd_e'(it.cmd) == CMD_WR_TRANS &&
          32'(it.from_state) < NUM_DFA_STATES && 32'(it.symbol) < NUM_SYMBOLS) begin
        row_valid_q[SW'(it.from_state)] <= 1'b1;
      end
      if (state_q == ST_FWD && last_st) begin
        fwd_q[lay_q + LayW'(1)] <= acc_q | tgt_c;
        if (lay_q + LayW'(1) == n_q) bwd_q <= (acc_q | tgt_c) & fmask_q[NUM_DFA_STATES-1:0];
      end
      if (state_q == ST_BWD && last_st) begin
        bwd_q <= acc_q | ((|vals_c) ? (NUM_DFA_STATES'(1) << st_q) : '0);
      end
      if (state_q == ST_EMIT && (!ovld_q || out_if.ready)) ovld_q <= 1'b1;
      else if (out_if.ready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && cmd_e'(it.cmd) == CMD_WR_TRANS &&
        32'(it.from_state) < NUM_DFA_STATES && 32'(it.symbol) < NUM_SYMBOLS) begin
      ttab_q[SW'(it.from_state)] <= row_wr;
    end
    if (in_fire && cmd_e'(it.cmd) == CMD_WR_DOM && 32'(it.var_index) < MAX_VARS)
      dom_q[VW'(it.var_index)] <= it.domain_mask;
    if (state_q == ST_BWD && last_st) keep_q[layk] <= vals_q | DomBits'(vals_c);
    if (state_q == ST_EMIT && (!ovld_q || out_if.ready)) begin
      dom_q[layv]       <= keep_q[layk];
      out_q.out_var     <= FieldW'(lay_q);
      out_q.pruned_mask <= keep_q[layk];
      out_q.wiped_out   <= (keep_q[layk] == '0);
      out_q.last        <= (lay_q + LayW'(1) == n_q);
    end
  end

  assign out_if.valid = ovld_q;
  assign out_if.data  = out_q;

  `DLDF_ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni, state_q != ST_IDLE, !in_if.ready,
    "input ready while busy")
  `DLDF_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_if.valid && !out_if.ready,
    out_if.valid && $stable(out_if.data), "stalled result changed")
  `DLDF_ASSERT_IMPL(a_lay_range, clk_i, rst_ni, state_q != ST_IDLE, lay_q < n_q,
    "layer index beyond length")
endmodule
